// ===== hw/rtl/bftr_pkg.sv =====
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared types, constants and codes of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package bftr_pkg;

  // Glyph store size (bytes), default for the top-level parameter; power of two
  localparam int unsigned FONT_STORE_BYTES_DEF = 16384;

  // Glyph geometry limits
  localparam int unsigned MAX_GLYPH_WIDTH  = 16;
  localparam int unsigned MAX_GLYPH_HEIGHT = 32;
  localparam int unsigned MAX_ROWS         = 32;
  localparam int unsigned ROW_CAP          =
      (MAX_GLYPH_HEIGHT < MAX_ROWS) ? MAX_GLYPH_HEIGHT : MAX_ROWS;

  // Field widths
  localparam int unsigned CUR_W      = 12;
  localparam int unsigned ADDR_W     = 31;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned BASE_W     = 30;
  localparam int unsigned PITCH_W    = 14;
  localparam int unsigned GW_W       = 5;
  localparam int unsigned GH_W       = 6;
  localparam int unsigned GC_W       = 9;
  localparam int unsigned GB_W       = 7;
  localparam int unsigned FADDR_W    = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 30;

  // Character codes
  localparam logic [7:0] CODE_RETURN  = 8'd13;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;

  // Opcodes
  localparam logic OP_FONT_WRITE = 1'b0;
  localparam logic OP_DRAW       = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_BASE   = 3'd0,
    REG_PITCH_BYTES  = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_GLYPH_COUNT  = 3'd4,
    REG_GLYPH_BYTES  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               opcode;
    logic [FADDR_W-1:0] font_addr;
    logic [7:0]         font_byte;
    logic [7:0]         char_code;
    logic               string_start;
    logic [CUR_W-1:0]   start_x;
    logic [CUR_W-1:0]   start_y;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row_address;
    logic [PIX_W-1:0]  row_pixels;
    logic              last_row;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // input transfer this cycle
    logic setup;  // compute glyph base and first row address
    logic issue;  // read one store byte
    logic shift;  // absorb a non-final byte of the row
    logic emit;   // load the output register with a finished row
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic draw;       // accepted item renders a glyph
    logic last_byte;  // byte in the read register closes the row
    logic last_row;   // current row is the final one
  } dp_status_t;

endpackage

// ===== hw/rtl/bftr_if.sv =====
// ----------------------------------------------------------------------------
// bftr_in_if / bftr_out_if
// Valid/ready channels for input items and row results.
// ----------------------------------------------------------------------------
interface bftr_in_if
  import bftr_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bftr_out_if
  import bftr_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bftr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bftr_ctrl
// Sequencer: accepts items, walks glyph bytes and rows, owns output valid.
// ----------------------------------------------------------------------------
module bftr_ctrl
  import bftr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_RD    = 4'b0100,
    ST_LOOP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && status_i.draw) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_RD;
      end
      ST_RD: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_LOOP;
      end
      ST_LOOP: begin
        if (!status_i.last_byte) begin
          cmd_o.shift = 1'b1;
          cmd_o.issue = 1'b1;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_row) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.issue = 1'b1;
          end
        end
        // otherwise hold: output register still full
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/bftr_dp.sv =====
// ----------------------------------------------------------------------------
// bftr_dp
// Datapath: configuration, cursor, glyph store, row assembly and addresses.
// ----------------------------------------------------------------------------
module bftr_dp
  import bftr_pkg::*;
#(
  parameter int unsigned FontStoreBytes = FONT_STORE_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  output out_item_t             out_data_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  localparam int unsigned SA_W = $clog2(FontStoreBytes);

  // Configuration
  logic [BASE_W-1:0]  frame_base_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [GW_W-1:0]    gwidth_q;
  logic [GH_W-1:0]    gheight_q;
  logic [GC_W-1:0]    gcount_q;
  logic [GB_W-1:0]    gbytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
      pitch_q      <= PITCH_W'(4096);
      gwidth_q     <= GW_W'(8);
      gheight_q    <= GH_W'(16);
      gcount_q     <= GC_W'(256);
      gbytes_q     <= GB_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_BASE:   frame_base_q <= cfg_data_i[BASE_W-1:0];
        REG_PITCH_BYTES:  pitch_q      <= cfg_data_i[PITCH_W-1:0];
        REG_GLYPH_WIDTH:  gwidth_q     <= cfg_data_i[GW_W-1:0];
        REG_GLYPH_HEIGHT: gheight_q    <= cfg_data_i[GH_W-1:0];
        REG_GLYPH_COUNT:  gcount_q     <= cfg_data_i[GC_W-1:0];
        REG_GLYPH_BYTES:  gbytes_q     <= cfg_data_i[GB_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [GW_W-1:0] w_eff;
  logic [GH_W-1:0] h_eff;
  logic [2:0]      bpr;
  logic [2:0]      sh;
  logic [5:0]      row_bits;

  always_comb begin
    w_eff = gwidth_q;
    if (gwidth_q == '0) begin
      w_eff = GW_W'(1);
    end else if (32'(gwidth_q) > MAX_GLYPH_WIDTH) begin
      w_eff = GW_W'(MAX_GLYPH_WIDTH);
    end
    h_eff = gheight_q;
    if (gheight_q == '0) begin
      h_eff = GH_W'(1);
    end else if (32'(gheight_q) > ROW_CAP) begin
      h_eff = GH_W'(ROW_CAP);
    end
  end

  assign bpr      = 3'((6'(w_eff) + 6'd7) >> 3);
  assign row_bits = {bpr, 3'b000};
  assign sh       = 3'(row_bits - 6'(w_eff));

  // Input decode
  logic is_ret, is_nl;
  assign is_ret        = (in_data_i.char_code == CODE_RETURN);
  assign is_nl         = (in_data_i.char_code == CODE_NEWLINE);
  assign status_o.draw = (in_data_i.opcode == OP_DRAW) && !is_ret && !is_nl;

  // Cursor
  logic [CUR_W-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [CUR_W-1:0] cx_ld, cy_ld;

  assign cx_ld = in_data_i.string_start ? in_data_i.start_x : cursor_x_q;
  assign cy_ld = in_data_i.string_start ? in_data_i.start_y : cursor_y_q;

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (cmd_i.take && (in_data_i.opcode == OP_DRAW)) begin
      cursor_x_d = cx_ld;
      cursor_y_d = cy_ld;
      if (is_ret) begin
        cursor_x_d = '0;
      end else if (is_nl) begin
        cursor_x_d = '0;
        cursor_y_d = cy_ld + CUR_W'(h_eff);
      end
    end else if (cmd_i.setup) begin
      cursor_x_d = cursor_x_q + CUR_W'(w_eff) + CUR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  // Glyph index
  logic [7:0] glyph_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      glyph_q <= ({1'b0, in_data_i.char_code} < gcount_q) ? in_data_i.char_code : 8'd0;
    end
  end

  // Glyph store
  logic [7:0]      mem [FontStoreBytes];
  logic [7:0]      rdata_q;
  logic [SA_W-1:0] rd_addr_q;
  logic [SA_W-1:0] wr_addr;
  logic            wr_en;

  assign wr_addr = SA_W'(in_data_i.font_addr);
  assign wr_en   = cmd_i.take && (in_data_i.opcode == OP_FONT_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_i.font_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  // Rows are stored back to back, so the read address just counts up
  logic [15:0] glyph_base;
  assign glyph_base = 16'(glyph_q) * 16'(gbytes_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      rd_addr_q <= SA_W'(glyph_base);
    end else if (cmd_i.issue) begin
      rd_addr_q <= rd_addr_q + SA_W'(1);
    end
  end

  // Row and byte counters
  logic [GH_W-1:0] row_q;
  logic [1:0]      byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      byte_q <= '0;
    end else if (cmd_i.setup) begin
      row_q  <= '0;
      byte_q <= '0;
    end else if (cmd_i.emit) begin
      row_q  <= row_q + GH_W'(1);
      byte_q <= '0;
    end else if (cmd_i.shift) begin
      byte_q <= byte_q + 2'd1;
    end
  end

  assign status_o.last_byte = ({1'b0, byte_q} == (bpr - 3'd1));
  assign status_o.last_row  = (row_q == (h_eff - GH_W'(1)));

  // Row assembly: earlier bytes of the row sit in acc_q, MSB-first
  logic [23:0] acc_q;
  logic [31:0] row_word, row_shifted, row_mask;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      acc_q <= {acc_q[15:0], rdata_q};
    end
  end

  assign row_word    = {acc_q, rdata_q};
  assign row_shifted = row_word >> sh;
  assign row_mask    = ~(32'hFFFF_FFFF << w_eff);

  // Framebuffer address of the current row
  logic [ADDR_W-1:0]          row_addr_q;
  logic [CUR_W+PITCH_W-1:0]   y_offset;

  assign y_offset = (CUR_W+PITCH_W)'(cursor_y_q) * (CUR_W+PITCH_W)'(pitch_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      row_addr_q <= ADDR_W'(frame_base_q) + ADDR_W'(y_offset)
                  + ADDR_W'({cursor_x_q, 2'b00});
    end else if (cmd_i.emit) begin
      row_addr_q <= row_addr_q + ADDR_W'(pitch_q);
    end
  end

  // Output register
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.row_address <= row_addr_q;
      out_q.row_pixels  <= PIX_W'(row_shifted & row_mask);
      out_q.last_row    <= status_o.last_row;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/bitmap_font_text_renderer.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer
// Draws bitmap-font characters as framebuffer row writes; holds the font.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake       | Carries
//  cfg     | in  | cfg_we_i        | register index, write data
//  in_i    | in  | valid / ready   | font write or character draw
//  out_o   | out | valid / ready   | row address, row pixels, last row
//
//  Font writes, return and newline are taken without leaving the idle state.
//  A drawn glyph is read through the single glyph store read port, bpr bytes
//  per glyph row and one byte per cycle unless the output register is full.
//  Rows are produced only while the output register is free, so a stalled
//  sink holds the row walk. Reset clears cursor and configuration registers;
//  the glyph store is not cleared.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer
  import bftr_pkg::*;
#(
  parameter int unsigned FontStoreBytes = FONT_STORE_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bftr_in_if.sink               in_i,
  bftr_out_if.source            out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bftr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bftr_dp #(
    .FontStoreBytes (FontStoreBytes)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .out_data_o (out_o.data),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== bench/bftr_row_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// bftr_row_sb_pkg
// Row scoreboard for the font renderer bench. It keeps its own copy of the
// glyph store, the cursor and the registers, works out the row writes that
// each transferred item should cause, and checks the rows coming out in order.
// ----------------------------------------------------------------------------
package bftr_row_sb_pkg;
  import bftr_pkg::*;

  class glyph_row_scoreboard;
    bit [7:0]           font_mem [FONT_STORE_BYTES_DEF];
    bit                 font_set [FONT_STORE_BYTES_DEF];
    logic [CUR_W-1:0]   cur_x      = '0;
    logic [CUR_W-1:0]   cur_y      = '0;
    logic [BASE_W-1:0]  frame_base = '0;
    logic [PITCH_W-1:0] pitch      = 14'd4096;
    logic [GW_W-1:0]    gw         = 5'd8;
    logic [GH_W-1:0]    gh         = 6'd16;
    logic [GC_W-1:0]    gcount     = 9'd256;
    logic [GB_W-1:0]    gbytes     = 7'd16;
    out_item_t          rows_due [$];
    int unsigned        mismatches = 0;

    function int unsigned width_px();
      if (gw == 0) return 1;
      if (gw > MAX_GLYPH_WIDTH) return MAX_GLYPH_WIDTH;
      return 32'(gw);
    endfunction

    function int unsigned height_rows();
      if (gh == 0) return 1;
      if (gh > ROW_CAP) return ROW_CAP;
      return 32'(gh);
    endfunction

    // Store address of byte k of row r of the glyph that code selects
    function int unsigned store_addr(logic [7:0] code, int unsigned r, int unsigned k);
      int unsigned glyph;
      int unsigned nb;
      glyph = (code < gcount) ? 32'(code) : 0;
      nb = (width_px() + 7) / 8;
      return (glyph * gbytes + r * nb + k) % FONT_STORE_BYTES_DEF;
    endfunction

    // First store byte a draw of code would read before it was written, or -1
    function int first_unloaded(logic [7:0] code);
      int unsigned r;
      int unsigned k;
      int unsigned a;
      if (code == CODE_RETURN || code == CODE_NEWLINE) return -1;
      for (r = 0; r < height_rows(); r++) begin
        for (k = 0; k < (width_px() + 7) / 8; k++) begin
          a = store_addr(code, r, k);
          if (!font_set[a]) return int'(a);
        end
      end
      return -1;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_BASE:   frame_base = val[BASE_W-1:0];
        REG_PITCH_BYTES:  pitch      = val[PITCH_W-1:0];
        REG_GLYPH_WIDTH:  gw         = val[GW_W-1:0];
        REG_GLYPH_HEIGHT: gh         = val[GH_W-1:0];
        REG_GLYPH_COUNT:  gcount     = val[GC_W-1:0];
        REG_GLYPH_BYTES:  gbytes     = val[GB_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      int unsigned w;
      int unsigned h;
      int unsigned nb;
      int unsigned r;
      int unsigned k;
      logic [31:0] bits;
      logic [63:0] addr;
      out_item_t   row;
      if (it.opcode == OP_FONT_WRITE) begin
        font_mem[it.font_addr] = it.font_byte;
        font_set[it.font_addr] = 1'b1;
        return;
      end
      if (it.string_start) begin
        cur_x = it.start_x;
        cur_y = it.start_y;
      end
      w  = width_px();
      h  = height_rows();
      nb = (w + 7) / 8;
      if (it.char_code == CODE_RETURN) begin
        cur_x = '0;
        return;
      end
      if (it.char_code == CODE_NEWLINE) begin
        cur_x = '0;
        cur_y = CUR_W'(cur_y + h);
        return;
      end
      for (r = 0; r < h; r++) begin
        bits = '0;
        for (k = 0; k < nb; k++)
          bits = (bits << 8) | 32'(font_mem[store_addr(it.char_code, r, k)]);
        // drop the pad bits on the right of the last byte
        bits = bits >> (8 * nb - w);
        addr = 64'(frame_base) + 64'(cur_y + r) * 64'(pitch) + 64'(cur_x) * 64'd4;
        row.row_address = addr[ADDR_W-1:0];
        row.row_pixels  = bits[PIX_W-1:0];
        row.last_row    = (r == h - 1);
        rows_due.push_back(row);
      end
      cur_x = CUR_W'(cur_x + w + 1);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      if (rows_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected row: expected none, actual address 0x%0h pixels 0x%0h",
                 $time, got.row_address, got.row_pixels);
        return;
      end
      want = rows_due.pop_front();
      compare_field("row_address", 64'(want.row_address), 64'(got.row_address));
      compare_field("row_pixels", 64'(want.row_pixels), 64'(got.row_pixels));
      compare_field("last_row", 64'(want.last_row), 64'(got.last_row));
    endfunction
  endclass

endpackage

// ===== bench/bitmap_font_text_renderer_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_test
// Self-checking bench for the font renderer. Loads glyph bytes ahead of every
// draw, runs directed corner cases and then random text under several font
// and framebuffer settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bftr_pkg::*;
  import bftr_row_sb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 20;
  localparam int unsigned RANDOM_PHASES   = 6;

  logic                  clk    = 1'b0;
  logic                  rst_n  = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    quiet  = 1'b0;
  int unsigned           cycles = 0;
  int unsigned           stall_left = 0;
  int unsigned           sent   = 0;

  glyph_row_scoreboard sb = new;

  bftr_in_if  in_if ();
  bftr_out_if out_if ();

  bitmap_font_text_renderer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_row(out_if.data);
  end

  // Sink side: stall in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode       = 1'($urandom);
    it.font_addr    = FADDR_W'($urandom);
    it.font_byte    = 8'($urandom);
    it.char_code    = 8'($urandom);
    it.string_start = 1'($urandom);
    it.start_x      = CUR_W'($urandom);
    it.start_y      = CUR_W'($urandom);
    return it;
  endfunction

  // Leaves valid high after the transfer so the next item can follow directly
  task automatic push_item(in_item_t it);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(it);
    sent++;
  endtask

  // Hold off input until every pending row has come out
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] base, int unsigned pitch,
                              int unsigned w, int unsigned h,
                              int unsigned count, int unsigned nbytes);
    drain();
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_PITCH_BYTES, CFG_DATA_W'(pitch));
    write_reg(REG_GLYPH_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_GLYPH_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_GLYPH_COUNT, CFG_DATA_W'(count));
    write_reg(REG_GLYPH_BYTES, CFG_DATA_W'(nbytes));
  endtask

  task automatic load_byte(int unsigned addr, logic [7:0] value);
    in_item_t it;
    it           = random_item();
    it.opcode    = OP_FONT_WRITE;
    it.font_addr = FADDR_W'(addr);
    it.font_byte = value;
    push_item(it);
  endtask

  // Fill any glyph bytes the draw would read before sending it
  task automatic draw(logic [7:0] code, bit start, logic [CUR_W-1:0] x,
                      logic [CUR_W-1:0] y);
    in_item_t it;
    int       a;
    a = sb.first_unloaded(code);
    while (a >= 0) begin
      load_byte(unsigned'(a), 8'($urandom));
      a = sb.first_unloaded(code);
    end
    it              = random_item();
    it.opcode       = OP_DRAW;
    it.char_code    = code;
    it.string_start = start;
    it.start_x      = x;
    it.start_y      = y;
    push_item(it);
  endtask

  task automatic random_config();
    int unsigned w;
    int unsigned h;
    int unsigned count;
    int unsigned nbytes;
    w      = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
    h      = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) :
             ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 32);
    count  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
    nbytes = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
    apply_config(CFG_DATA_W'($urandom), $urandom_range(0, 16383), w, h, count, nbytes);
  endtask

  // Send about n items, glyph loads included
  task automatic run_random(int unsigned n);
    int unsigned stop;
    int unsigned r;
    int unsigned c;
    logic [7:0]  code;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 3 && !quiet) drain();
      if (r < 15) begin
        load_byte($urandom_range(0, FONT_STORE_BYTES_DEF - 1), 8'($urandom));
      end else begin
        c    = $urandom_range(0, 9);
        code = (c == 0) ? CODE_RETURN :
               (c == 1) ? CODE_NEWLINE :
               (c < 4)  ? 8'($urandom) : 8'($urandom_range(48, 55));
        draw(code, $urandom_range(0, 3) == 0, CUR_W'($urandom), CUR_W'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned p;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_FRAME_BASE;
    cfg_data     = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Reset font geometry: 8x16, 256 glyphs
    load_byte(FONT_STORE_BYTES_DEF - 1, 8'hFF);
    load_byte(0, 8'h00);
    draw(8'd65, 1'b1, 12'd0, 12'd0);
    draw(8'd255, 1'b1, 12'hFFF, 12'hFFF);
    draw(8'd0, 1'b0, 12'd0, 12'd0);
    draw(CODE_RETURN, 1'b0, 12'd0, 12'd0);
    draw(CODE_NEWLINE, 1'b1, 12'd100, 12'hFF8);
    draw(8'd66, 1'b0, 12'd0, 12'd0);

    // Smallest geometry; codes past the glyph count fall back to glyph zero
    apply_config('0, 0, 1, 1, 1, 1);
    draw(8'd0, 1'b1, 12'd0, 12'd0);
    draw(8'd200, 1'b0, 12'd0, 12'd0);
    draw(CODE_NEWLINE, 1'b0, 12'd0, 12'd0);
    draw(8'd5, 1'b0, 12'd0, 12'd0);

    // Largest geometry
    apply_config(30'h3FFFFFFF, 16383, 16, 32, 256, 64);
    draw(8'd0, 1'b1, 12'hFFF, 12'hFFF);
    draw(8'd0, 1'b0, 12'd0, 12'd0);
    draw(CODE_NEWLINE, 1'b0, 12'd0, 12'd0);

    // Width and height beyond their limits saturate; zero glyph count
    apply_config('0, 4096, 31, 63, 0, 0);
    draw(8'd77, 1'b1, 12'd8, 12'd8);
    draw(CODE_RETURN, 1'b0, 12'd0, 12'd0);
    draw(8'd78, 1'b0, 12'd0, 12'd0);

    // Zero width and height; glyph base wraps around the store
    apply_config(30'h12345, 2560, 0, 0, 511, 127);
    draw(8'd255, 1'b1, 12'd640, 12'd480);
    draw(8'd130, 1'b0, 12'd0, 12'd0);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      quiet = (p == RANDOM_PHASES - 1);
      run_random(ITEMS_PER_PHASE);
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
